// ===== design/wpls_pkg.sv =====
// Shared types and constants for the weighted priority level scheduler.
// No dependencies; imported by wpls_thr_gen and the top level.
`default_nettype none

package wpls_pkg;

   // Number of priority levels
   localparam int LEVELS     = 8;
   localparam int LVL_W      = $clog2(LEVELS);
   // Fixed widths of the transaction fields
   localparam int MASK_W     = 8;
   localparam int GRANT_W    = 3;
   localparam int ALPHA_W    = 16;
   // Unsigned Q16.8 credit and threshold format
   localparam int Q_W        = 24;
   localparam int FRAC_W     = 8;
   localparam int PROD_W     = Q_W + ALPHA_W;

   localparam logic [Q_W-1:0]     Q_ONE     = Q_W'(256);
   localparam logic [Q_W-1:0]     Q_MAX     = {Q_W{1'b1}};
   localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(512);

   // CSR map: register index is byte address / 4
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ALPHA = 1'b0;

   typedef logic [Q_W-1:0] q_type;
   typedef q_type [LEVELS-1:0] thr_arr_type;

   // Threshold build sequencer states
   typedef enum logic {
      BLD_IDLE,
      BLD_RUN
   } bld_state_type;

endpackage

`default_nettype wire

// ===== design/wpls_thr_gen.sv =====
// Threshold table builder: thr[k] = alpha^(LEVELS-1-k) in saturating Q16.8.
// One multiply per cycle from the top level downward; uses wpls_pkg.
`default_nettype none

module wpls_thr_gen (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wpls_pkg::ALPHA_W-1:0]  alpha,
   output logic                          busy,
   output wpls_pkg::thr_arr_type         thr
);
   import wpls_pkg::*;

   bld_state_type           state_ff, state_in;
   logic [LVL_W-1:0]        idx_ff;
   q_type                   c_ff;
   thr_arr_type             thr_ff;
   logic                    load;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W-FRAC_W-1:0] prod_sh;
   q_type                   c_next;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BLD_IDLE: begin
            if (start) state_in = BLD_RUN;
         end
         BLD_RUN: begin
            if (start)               state_in = BLD_RUN;
            else if (idx_ff == '0)   state_in = BLD_IDLE;
         end
         default: state_in = BLD_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      load = 1'b0;
      busy = 1'b0;
      unique case (state_ff)
         BLD_IDLE: begin
            busy = 1'b0;
         end
         BLD_RUN: begin
            load = !start;
            busy = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   // Next power of alpha, truncated and saturated
   assign prod    = PROD_W'(c_ff) * PROD_W'(alpha);
   assign prod_sh = prod[PROD_W-1:FRAC_W];
   assign c_next  = (|prod_sh[PROD_W-FRAC_W-1:Q_W]) ? Q_MAX : prod_sh[Q_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BLD_RUN;
         idx_ff   <= LVL_W'(LEVELS-1);
         c_ff     <= Q_ONE;
      end else begin
         state_ff <= state_in;
         if (start) begin
            idx_ff <= LVL_W'(LEVELS-1);
            c_ff   <= Q_ONE;
         end else if (load) begin
            idx_ff <= idx_ff - 1'b1;
            c_ff   <= c_next;
         end
      end
   end

   // Table write, one level per cycle
   always_ff @(posedge clock) begin
      for (int k = 0; k < LEVELS; k++) begin
         if (load && (idx_ff == LVL_W'(k))) thr_ff[k] <= c_ff;
      end
   end

   assign thr = thr_ff;

endmodule

`default_nettype wire

// ===== design/weighted_priority_level_scheduler_unit.sv =====
// Top level of the weighted priority level scheduler: input register, grant
// logic with credit counters, result register and CSR port.
// Depends on wpls_pkg and wpls_thr_gen.
//
//  Channel | Direction | Handshake            | Contents
//  req     | in        | tvalid/tready        | tdata[7:0] nonempty_mask
//  rsp     | out       | tvalid/tready        | tuser[0] grant_valid, tdata[2:0] grant_level
//  csr     | in/out    | psel/penable/pready  | reg 0 @0x0: alpha, Q8.8
//
// One transaction per cycle sustained while rsp is ready and no build runs; a request
// is taken into the input register, and its grant then into the result register.
// The credit update and grant decision is one pass of per-level add/compare.
// After reset and after each alpha write the threshold table is rebuilt by a
// single multiplier; req_tready is low during the build.
// A stalled rsp holds its result while one more request waits in the input register.
`default_nettype none

module weighted_priority_level_scheduler_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] nonempty_mask
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [2:0] grant_level, [7:3] zero
   output logic [0:0]                        rsp_tuser,   // [0] grant_valid
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wpls_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wpls_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wpls_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wpls_pkg::*;

   logic [ALPHA_W-1:0]  alpha_ff;
   logic                alpha_wr;
   logic                bld_busy;
   thr_arr_type         thr;

   logic                in_valid_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic                rsp_valid_ff;
   logic                gvalid_ff;
   logic [GRANT_W-1:0]  glevel_ff;
   thr_arr_type         credit_ff;

   logic                fire;
   logic [LEVELS-1:0]   lvl_on;
   logic [LEVELS-1:0]   crossed;
   thr_arr_type         credit_in;
   logic [ALPHA_W-1:0]  inc;
   logic [GRANT_W-1:0]  top_lvl;
   logic [GRANT_W-1:0]  grant_in;
   logic                gvalid_in;

   // CSR access
   assign csr_pready = 1'b1;
   assign alpha_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ALPHA);
   assign csr_prdata = (csr_paddr[2] == REG_ALPHA) ? CSR_DATA_W'(alpha_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset)         alpha_ff <= ALPHA_RST;
      else if (alpha_wr) alpha_ff <= csr_pwdata[ALPHA_W-1:0];
   end

   // Threshold table
   wpls_thr_gen u_thr_gen (
      .clock (clock),
      .reset (reset),
      .start (alpha_wr),
      .alpha (alpha_ff),
      .busy  (bld_busy),
      .thr   (thr)
   );

   // Handshake: the grant pass runs when a request is held, no build runs and the result register can take a value
   assign fire       = in_valid_ff && !bld_busy && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !bld_busy && (!in_valid_ff || fire);

   // Level occupancy; mask bits beyond the level count are dropped
   for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      if (k < MASK_W) begin : g_in
         assign lvl_on[k] = mask_ff[k];
      end else begin : g_none
         assign lvl_on[k] = 1'b0;
      end
   end

   // Increment is 1.0 when the top level is occupied, else alpha
   assign inc = lvl_on[LEVELS-1] ? ALPHA_W'(Q_ONE) : alpha_ff;

   // Per-level credit add, saturate, compare, subtract
   always_comb begin
      logic [Q_W:0] sum;
      for (int k = 0; k < LEVELS; k++) begin
         sum = {1'b0, credit_ff[k]} + (Q_W+1)'(inc);
         if (sum[Q_W]) sum = {1'b0, Q_MAX};
         crossed[k]   = lvl_on[k] && (sum[Q_W-1:0] >= thr[k]);
         credit_in[k] = credit_ff[k];
         if (lvl_on[k]) credit_in[k] = crossed[k] ? (sum[Q_W-1:0] - thr[k]) : sum[Q_W-1:0];
      end
   end

   // Grant: lowest crossing level, else highest occupied level
   always_comb begin
      top_lvl = '0;
      for (int k = 0; k < LEVELS; k++) begin
         if (lvl_on[k]) top_lvl = GRANT_W'(k);
      end
      grant_in = top_lvl;
      for (int k = LEVELS-1; k >= 0; k--) begin
         if (crossed[k]) grant_in = GRANT_W'(k);
      end
      gvalid_in = |lvl_on;
      if (!gvalid_in) grant_in = '0;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) mask_ff <= req_tdata[MASK_W-1:0];
   end

   // Credit counters
   always_ff @(posedge clock) begin
      if (reset || alpha_wr) begin
         credit_ff <= '0;
      end else if (fire) begin
         credit_ff <= credit_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         gvalid_ff <= gvalid_in;
         glevel_ff <= grant_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {{(8-GRANT_W){1'b0}}, glevel_ff};
   assign rsp_tuser[0] = gvalid_ff;

   // Checks
   a_no_req_in_build: assert property (@(posedge clock) disable iff (reset)
      bld_busy |-> !req_tready)
      else $error("request taken during threshold build");

   a_empty_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("empty grant carries a nonzero level");

   a_alpha_clears: assert property (@(posedge clock) disable iff (reset)
      alpha_wr |=> (credit_ff == '0))
      else $error("credits not cleared after alpha write");

   a_grant_occupied: assert property (@(posedge clock) disable iff (reset)
      (fire && gvalid_in) |-> lvl_on[grant_in[LVL_W-1:0]])
      else $error("granted level has no waiting item");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for weighted_priority_level_scheduler_unit.
// Drives mask transactions and alpha writes, predicts every grant in place.
// Depends on wpls_pkg and the scheduler RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wpls_pkg::*;

   // CSR byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_ALPHA    = {REG_ALPHA, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = CSR_ADDR_W'(4);
   // Cycles with no transaction on any port before the run is abandoned
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic               valid;
      logic [GRANT_W-1:0] level;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;    // [7:0] nonempty_mask
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [2:0] grant_level, [7:3] zero
   logic [0:0]            rsp_tuser;         // [0] grant_valid
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Scheduler state as the checker sees it
   logic [ALPHA_W-1:0] alpha_reg;
   q_type              level_credit [LEVELS];
   q_type              level_thr [LEVELS];

   grant_type grant_q [$];
   int        mismatch_count = 0;
   bit        no_idle = 1'b0;
   int        quiet_cycles = 0;

   weighted_priority_level_scheduler_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Threshold table: level LEVELS-1 is 1.0, each level below scales by alpha
   function automatic void rebuild_thresholds();
      logic [PROD_W-1:0] acc;
      int                k;
      acc = PROD_W'(Q_ONE);
      for (k = LEVELS - 1; k >= 0; k--) begin
         level_thr[k] = acc[Q_W-1:0];
         acc = (acc * alpha_reg) >> FRAC_W;
         if (acc > Q_MAX) acc = PROD_W'(Q_MAX);
      end
   endfunction

   function automatic void load_alpha(input logic [ALPHA_W-1:0] value);
      int k;
      alpha_reg = value;
      for (k = 0; k < LEVELS; k++) level_credit[k] = '0;
      rebuild_thresholds();
   endfunction

   // Credit update and grant decision for one service opportunity
   function automatic grant_type predict_grant(input logic [MASK_W-1:0] mask);
      int           top;
      int           k;
      logic [Q_W:0] sum;
      q_type        inc;
      grant_type    g;
      top = -1;
      g = '0;
      for (k = 0; k < LEVELS && k < MASK_W; k++)
         if (mask[k]) top = k;
      if (top < 0) return g;
      inc = (top == LEVELS - 1) ? Q_ONE : q_type'(alpha_reg);
      g.valid = 1'b1;
      g.level = GRANT_W'(top);
      for (k = top; k >= 0; k--) begin
         if (mask[k]) begin
            sum = {1'b0, level_credit[k]} + {1'b0, inc};
            if (sum > Q_MAX) sum = {1'b0, Q_MAX};
            // a zero threshold always crosses and subtracts nothing
            if (sum >= level_thr[k]) begin
               sum = sum - level_thr[k];
               g.level = GRANT_W'(k);
            end
            level_credit[k] = sum[Q_W-1:0];
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
      $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, exp_v, got_v);
      mismatch_count++;
   endtask

   // Send one mask transaction, with an optional idle burst first
   task automatic send_mask(input logic [MASK_W-1:0] mask);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mask;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      grant_q.push_back(predict_grant(mask));
   endtask

   // Stop sending and wait for every pending grant
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_alpha_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_ALPHA;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[ALPHA_W-1:0] !== alpha_reg)
         report_mismatch("alpha readback", 32'(alpha_reg), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Alpha is only written with the pipe empty
   task automatic set_alpha(input logic [ALPHA_W-1:0] value);
      wait_drain();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      csr_write(ADDR_ALPHA, {(CSR_DATA_W-ALPHA_W)'($urandom), value});
      load_alpha(value);
      check_alpha_readback();
   endtask

   // Random mask with a bias toward top-level, single-level and empty cases
   function automatic logic [MASK_W-1:0] random_mask();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
         2:       return 8'h80 | 8'($urandom);
         3, 4:    return 8'h7F & 8'($urandom);
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      logic [MASK_W-1:0] masks [12];
      int                i;
      masks = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h7F, 8'hAA, 8'h55,
                8'h03, 8'h03, 8'h40, 8'h00};
      check_alpha_readback();
      for (i = 0; i < 12; i++) send_mask(masks[i]);
   endtask

   task automatic test_alpha_extremes();
      // alpha zero: every threshold below the top level is zero
      set_alpha(16'h0000);
      send_mask(8'h0F);
      send_mask(8'h81);
      send_mask(8'h01);
      // alpha maximum: thresholds saturate
      set_alpha(16'hFFFF);
      send_mask(8'h7F);
      send_mask(8'hFF);
      send_mask(8'h40);
      // alpha one: all thresholds equal 1.0
      set_alpha(16'h0100);
      send_mask(8'hFF);
      send_mask(8'h3C);
   endtask

   // A write beyond register 0 must leave alpha and the credits alone
   task automatic test_unmapped_write();
      wait_drain();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      csr_write(ADDR_UNMAPPED, CSR_DATA_W'($urandom));
      check_alpha_readback();
      send_mask(8'h3C);
      send_mask(8'h24);
      send_mask(8'hC3);
   endtask

   // Level 0 is occupied at every opportunity, so its credit climbs to the Q16.8 ceiling
   task automatic test_credit_saturation();
      int i;
      set_alpha(16'hFFFF);
      for (i = 0; i < 300; i++) send_mask(8'h01 | (8'h3F & 8'($urandom)));
   endtask

   task automatic run_random_phase(input logic [ALPHA_W-1:0] value, input int count);
      int                i;
      int                n;
      int                run_len;
      logic [MASK_W-1:0] m;
      set_alpha(value);
      n = 0;
      while (n < count) begin
         if (n >= count / 2 && n < count / 2 + 1) wait_drain();
         if ($urandom_range(0, 7) == 0) begin
            // run of one mask so credits build up on the same levels
            m = random_mask();
            run_len = $urandom_range(5, 30);
            for (i = 0; i < run_len; i++) send_mask(m);
            n += run_len;
         end else begin
            send_mask(random_mask());
            n++;
         end
      end
   endtask

   task automatic test_random();
      run_random_phase(16'($urandom), 120);
      run_random_phase(16'h0001, 120);
      run_random_phase(16'h0180, 120);
      run_random_phase(16'($urandom_range(16'h0100, 16'h0400)), 120);
      run_random_phase(16'hFFFF, 120);
      run_random_phase(16'h0000, 120);
      run_random_phase(16'($urandom), 120);
   endtask

   task automatic test_back_to_back();
      wait_drain();
      no_idle = 1'b1;
      run_random_phase(16'h0200, 130);
   endtask

   // Result stall generator
   initial begin
      @(negedge reset);
      forever begin
         if (no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Grant checker
   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            report_mismatch("grant with nothing pending", 32'(0),
                            32'({rsp_tuser, rsp_tdata}));
         end else begin
            exp_g = grant_q.pop_front();
            if (rsp_tuser[0] !== exp_g.valid)
               report_mismatch("grant_valid", 32'(exp_g.valid), 32'(rsp_tuser));
            if (rsp_tdata !== {5'b0, exp_g.level})
               report_mismatch("grant_level", 32'(exp_g.level), 32'(rsp_tdata));
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      load_alpha(ALPHA_RST);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_alpha_extremes();
      test_unmapped_write();
      test_credit_saturation();
      test_random();
      test_back_to_back();
      req_tvalid <= 1'b0;
      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/wpls_pkg.sv
design/wpls_thr_gen.sv
design/weighted_priority_level_scheduler_unit.sv
sim/tb.sv
